@@ sv/thsm_pkg.sv @@
// ----------------------------------------------------------------------------
// thsm_pkg
// Shared types, register codes, status and zone codes and the code-to-
// temperature table of the thermal sample zone monitor.
// ----------------------------------------------------------------------------
package thsm_pkg;

    // temperature in millidegrees Celsius
    typedef logic signed [17:0] temp_t;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SENSOR_ENABLED = 2'd0;
    localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
    localparam logic [1:0] STATUS_BAD_CODE = 2'd2;

    // zone codes
    localparam logic [1:0] ZONE_UNDEFINED = 2'd0;
    localparam logic [1:0] ZONE_BELOW     = 2'd1;
    localparam logic [1:0] ZONE_BETWEEN   = 2'd2;
    localparam logic [1:0] ZONE_ABOVE     = 2'd3;

    // reset values of the registers
    localparam logic       RESET_ENABLED  = 1'b1;
    localparam logic [6:0] RESET_LOW_THR  = 7'd75;
    localparam logic [6:0] RESET_HIGH_THR = 7'd76;

    // last valid code of the table
    localparam logic [7:0] TABLE_LAST_CODE = 8'd95;

    // sample at least this far above the average takes the fast weights
    localparam logic signed [18:0] JUMP_MARGIN = 19'sd35000;

    // exact divide by ten for magnitudes below 2^21: floor(x * M / 2^25)
    localparam int unsigned      DIV10_SHIFT = 25;
    localparam logic      [21:0] DIV10_MULT  = 22'd3355444;

    // table entries past the last listed one read as the saturated top
    localparam logic [6:0] ROM_LAST = 7'd107;
    localparam temp_t      ROM_TOP  = 18'sd125000;

    localparam temp_t CODE_ROM [0:107] = '{
        -18'sd40000, -18'sd40000, -18'sd40000, -18'sd40000,
        -18'sd40000, -18'sd40000, -18'sd40000, -18'sd40000,
        -18'sd40000, -18'sd40000, -18'sd40000, -18'sd40000,
        -18'sd40000, -18'sd39000, -18'sd36500, -18'sd34500,
        -18'sd33000, -18'sd31000, -18'sd29000, -18'sd27000,
        -18'sd25000, -18'sd23000, -18'sd21000, -18'sd19250,
        -18'sd17750, -18'sd16000, -18'sd14250, -18'sd12750,
        -18'sd11000, -18'sd9000,  -18'sd7250,  -18'sd5750,
        -18'sd4250,  -18'sd2500,  -18'sd750,   18'sd1000,
        18'sd2750,   18'sd4250,   18'sd5750,   18'sd7500,
        18'sd9250,   18'sd11000,  18'sd12750,  18'sd14250,
        18'sd16000,  18'sd18000,  18'sd20000,  18'sd22000,
        18'sd24000,  18'sd26000,  18'sd27750,  18'sd29250,
        18'sd31000,  18'sd32750,  18'sd34250,  18'sd36000,
        18'sd37750,  18'sd39250,  18'sd41000,  18'sd42750,
        18'sd44250,  18'sd46000,  18'sd47750,  18'sd49250,
        18'sd51000,  18'sd52750,  18'sd54250,  18'sd56000,
        18'sd57750,  18'sd59250,  18'sd61000,  18'sd63000,
        18'sd65000,  18'sd67000,  18'sd69000,  18'sd70750,
        18'sd72500,  18'sd74250,  18'sd76000,  18'sd77750,
        18'sd79250,  18'sd81000,  18'sd82750,  18'sd84250,
        18'sd86000,  18'sd87750,  18'sd89250,  18'sd91000,
        18'sd92750,  18'sd94250,  18'sd96000,  18'sd97750,
        18'sd99250,  18'sd101000, 18'sd102750, 18'sd104250,
        18'sd106000, 18'sd108000, 18'sd110000, 18'sd112000,
        18'sd114000, 18'sd116000, 18'sd117750, 18'sd119250,
        18'sd121000, 18'sd122750, 18'sd124250, 18'sd125000
    };

    // configuration as seen by the datapath
    typedef struct packed {
        logic       enabled;
        logic [6:0] low_thr;
        logic [6:0] high_thr;
    } cfg_t;

    // one computed result, plus whether it commits new state
    typedef struct packed {
        logic [1:0] status;
        temp_t      sample_temp;
        temp_t      average_temp;
        logic [1:0] zone;
        logic       crossed;
        logic       commit;
    } result_t;

    // table lookup, saturating past the listed entries
    function automatic temp_t rom_read(input logic [6:0] code);
        temp_t val;
        if (code > ROM_LAST) begin
            val = ROM_TOP;
        end else begin
            val = CODE_ROM[code];
        end
        return val;
    endfunction

endpackage

@@ sv/thermal_sample_zone_monitor.sv @@
// ----------------------------------------------------------------------------
// thermal_sample_zone_monitor
// Path: a sample transaction passes the input register, then the result
//   register, before its result is valid.
// Throughput: one sample per cycle unless m_tready stalls; a good sample
//   sets average and last zone in the cycle it enters the result register.
// Reset (aresetn low, synchronous): both channels empty, average 0,
//   zone undefined, registers at enable 1, low 75, high 76.
// ----------------------------------------------------------------------------
module thermal_sample_zone_monitor
    import thsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // sample channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] adc_code
    input  logic [0:0]  s_tuser,   // [0] conversion_timeout
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [17:0] sample_temp, [35:18] average_temp,
                                   // [37:36] zone, [38] crossed, [39] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg;
    result_t    res;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_code_reg;
    logic       in_timeout_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_res_reg;
    temp_t      avg_reg;
    logic [1:0] last_zone_reg;
    logic       in_accept;
    logic       advance;
    logic       produce;

    thsm_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    thsm_update u_update (
        .adc_code           (in_code_reg),
        .conversion_timeout (in_timeout_reg),
        .cfg                (cfg),
        .avg                (avg_reg),
        .last_zone          (last_zone_reg),
        .res                (res)
    );

    // handshake: the input stage moves on whenever the result slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign produce   = advance && cfg.enabled;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (produce) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            avg_reg       <= '0;
            last_zone_reg <= ZONE_UNDEFINED;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (produce && res.commit) begin
                avg_reg       <= res.average_temp;
                last_zone_reg <= res.zone;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_code_reg    <= s_tdata;
            in_timeout_reg <= s_tuser[0];
        end
        if (produce) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {1'b0, out_res_reg.crossed, out_res_reg.zone,
                       out_res_reg.average_temp, out_res_reg.sample_temp};

endmodule

@@ sv/thsm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// thsm_cfg_regs
// APB register file: sensor enable and the two zone thresholds.
// ----------------------------------------------------------------------------
module thsm_cfg_regs
    import thsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_SENSOR_ENABLED: cfg_next.enabled  = pwdata[0];
                REG_LOW_THRESHOLD:  cfg_next.low_thr  = pwdata[6:0];
                REG_HIGH_THRESHOLD: cfg_next.high_thr = pwdata[6:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled  <= RESET_ENABLED;
            cfg_reg.low_thr  <= RESET_LOW_THR;
            cfg_reg.high_thr <= RESET_HIGH_THR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_SENSOR_ENABLED: prdata = {31'd0, cfg_reg.enabled};
            REG_LOW_THRESHOLD:  prdata = {25'd0, cfg_reg.low_thr};
            REG_HIGH_THRESHOLD: prdata = {25'd0, cfg_reg.high_thr};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/thsm_update.sv @@
// ----------------------------------------------------------------------------
// thsm_update
// Per-sample logic: status check, table lookup, zone classification and
// weighted running-average update with truncating divide by ten.
// ----------------------------------------------------------------------------
module thsm_update
    import thsm_pkg::*;
(
    input  logic [7:0] adc_code,
    input  logic       conversion_timeout,
    input  cfg_t       cfg,
    input  temp_t      avg,
    input  logic [1:0] last_zone,
    output result_t    res
);

    logic [1:0]         status;
    temp_t              sample;
    logic [1:0]         zone;
    logic signed [18:0] jump_limit;
    logic signed [21:0] s_ext;
    logic signed [21:0] a_ext;
    logic signed [21:0] num;
    logic        [20:0] mag;
    logic        [42:0] prod;
    logic        [16:0] quot;
    temp_t              new_avg;

    // status: timeout wins over a code past the table
    always_comb begin
        priority if (conversion_timeout) begin
            status = STATUS_TIMEOUT;
        end else if (adc_code > TABLE_LAST_CODE) begin
            status = STATUS_BAD_CODE;
        end else begin
            status = STATUS_OK;
        end
    end

    assign sample = rom_read(adc_code[6:0]);

    // zone against the code thresholds
    always_comb begin
        priority if (adc_code < {1'b0, cfg.low_thr}) begin
            zone = ZONE_BELOW;
        end else if (adc_code < {1'b0, cfg.high_thr}) begin
            zone = ZONE_BETWEEN;
        end else begin
            zone = ZONE_ABOVE;
        end
    end

    // weights 9/1 normally, 7/3 on a large upward jump (then divide by ten)
    assign jump_limit = 19'(avg) + JUMP_MARGIN;
    assign s_ext      = 22'(sample);
    assign a_ext      = 22'(avg);

    always_comb begin
        if (19'(sample) < jump_limit) begin
            num = (s_ext <<< 3) + s_ext + a_ext;
        end else begin
            num = (s_ext <<< 3) - s_ext + (a_ext <<< 1) + a_ext;
        end
    end

    // signed divide by ten via reciprocal multiply on the magnitude
    assign mag  = num[21] ? 21'(-num) : num[20:0];
    assign prod = 43'(mag) * 43'(DIV10_MULT);
    assign quot = prod[DIV10_SHIFT +: 17];

    assign new_avg = num[21] ? -temp_t'({1'b0, quot}) : temp_t'({1'b0, quot});

    // result assembly
    always_comb begin
        res.status = status;
        if (status == STATUS_OK) begin
            res.sample_temp  = sample;
            res.average_temp = new_avg;
            res.zone         = zone;
            res.crossed      = (zone != last_zone);
            res.commit       = 1'b1;
        end else begin
            res.sample_temp  = '0;
            res.average_temp = avg;
            res.zone         = last_zone;
            res.crossed      = 1'b0;
            res.commit       = 1'b0;
        end
    end

endmodule

@@ sv/thsm_checker.sv @@
// ----------------------------------------------------------------------------
// thsm_checker
// Port-level checks of the thermal sample zone monitor, bound to the top.
// ----------------------------------------------------------------------------
module thsm_checker
    import thsm_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // no result right after a reset cycle
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // status is one of the defined codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_TIMEOUT
                      || m_tuser == STATUS_BAD_CODE))
        else $error("bad status code");

    // error transactions carry no sample and never flag a crossing
    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |-> m_tdata[17:0] == 18'd0 && !m_tdata[38])
        else $error("error result with sample or crossing");

    // a good sample always lands in a defined zone
    a_ok_zone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_OK |-> m_tdata[37:36] != ZONE_UNDEFINED)
        else $error("good sample with undefined zone");

endmodule

bind thermal_sample_zone_monitor thsm_checker u_thsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
